[src/bbc_pkg.sv]
// shared constants, types and helpers for the bracket balance checker
`timescale 1ns / 1ps
package bbc_pkg;

  localparam int STACK_DEPTH    = 64;
  localparam int POSITION_WIDTH = 16;
  localparam int LVL_W          = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W         = $clog2(STACK_DEPTH);

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

  localparam logic [2:0] VERDICT_OK         = 3'd0;
  localparam logic [2:0] VERDICT_NO_OPENER  = 3'd1;
  localparam logic [2:0] VERDICT_MISMATCH   = 3'd2;
  localparam logic [2:0] VERDICT_NO_CLOSER  = 3'd3;
  localparam logic [2:0] VERDICT_OVERFLOW   = 3'd4;

  localparam logic [1:0] KIND_PAREN = 2'd0;
  localparam logic [1:0] KIND_BRACK = 2'd1;
  localparam logic [1:0] KIND_BRACE = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [1:0] kind;
  } stk_cmd_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [1:0]       tos;
    logic [1:0]       below;
  } stk_stat_t;

  function automatic logic [1:0] opener_kind(input logic [7:0] c);
    logic [1:0] k;
    case (c)
      CH_LPAREN: k = KIND_PAREN;
      CH_LBRACK: k = KIND_BRACK;
      CH_LBRACE: k = KIND_BRACE;
      default:   k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [1:0] closer_kind(input logic [7:0] c);
    logic [1:0] k;
    case (c)
      CH_RPAREN: k = KIND_PAREN;
      CH_RBRACK: k = KIND_BRACK;
      CH_RBRACE: k = KIND_BRACE;
      default:   k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] kind_char(input logic [1:0] k);
    logic [7:0] c;
    case (k)
      KIND_PAREN: c = CH_LPAREN;
      KIND_BRACK: c = CH_LBRACK;
      KIND_BRACE: c = CH_LBRACE;
      default:    c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[src/bbc_if.sv]
// input and output word channels of the bracket balance checker
`timescale 1ns / 1ps
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface bbc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [15:0] error_line;
  logic [15:0] error_column;
  logic [7:0]  error_char;

  modport source (output valid, output verdict, output error_line, output error_column,
                  output error_char, input ready);
  modport sink   (input valid, input verdict, input error_line, input error_column,
                  input error_char, output ready);
endinterface

[src/bbc_stack.sv]
// bracket stack: top entry in a register, the rest in a synchronous ram that is read ahead at the entry under the top
`timescale 1ns / 1ps
module bbc_stack
  import bbc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  stk_cmd_t  cmd_i,
  output stk_stat_t stat_o
);

  logic [1:0]       mem [STACK_DEPTH];
  logic [LVL_W-1:0] level_q, level_d;
  logic [1:0]       tos_q, tos_d;
  logic [1:0]       rd_q;
  logic             fwd_q, fwd_d;
  logic [1:0]       fwd_data_q;
  logic             wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [1:0]       below;

  assign below   = fwd_q ? fwd_data_q : rd_q;
  assign wr_en   = cmd_i.push && (level_q != '0);
  assign wr_addr = ADDR_W'(level_q - LVL_W'(1));

  always_comb begin
    level_d = level_q;
    tos_d   = tos_q;
    if (cmd_i.push) begin
      level_d = level_q + LVL_W'(1);
      tos_d   = cmd_i.kind;
    end else if (cmd_i.pop) begin
      level_d = level_q - LVL_W'(1);
      tos_d   = below;
    end
    if (cmd_i.clear) begin
      level_d = '0;
    end
  end

  // entry just under the top for the next level
  assign rd_addr = ADDR_W'(level_d - LVL_W'(2));
  assign fwd_d   = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= tos_q;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= tos_q;
    tos_q      <= tos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      fwd_q   <= 1'b0;
    end else begin
      level_q <= level_d;
      fwd_q   <= fwd_d;
    end
  end

  assign stat_o.level = level_q;
  assign stat_o.tos   = tos_q;
  assign stat_o.below = below;

endmodule

[src/bbc_pos.sv]
// saturating line and column counters
`timescale 1ns / 1ps
module bbc_pos
  import bbc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      newline_i,
  input  logic                      clear_i,
  output logic [POSITION_WIDTH-1:0] line_o,
  output logic [POSITION_WIDTH-1:0] column_o
);

  logic [POSITION_WIDTH-1:0] line_q, line_d;
  logic [POSITION_WIDTH-1:0] col_q, col_d;
  logic [POSITION_WIDTH-1:0] line_inc, col_inc;

  assign line_inc = (line_q == POS_MAX) ? POS_MAX : line_q + POSITION_WIDTH'(1);
  assign col_inc  = (col_q == POS_MAX) ? POS_MAX : col_q + POSITION_WIDTH'(1);

  always_comb begin
    line_o   = line_q;
    column_o = col_q;
    if (step_i) begin
      if (newline_i) begin
        line_o   = line_inc;
        column_o = '0;
      end else begin
        column_o = col_inc;
      end
    end
    line_d = clear_i ? POSITION_WIDTH'(1) : line_o;
    col_d  = clear_i ? '0 : column_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= POSITION_WIDTH'(1);
      col_q  <= '0;
    end else begin
      line_q <= line_d;
      col_q  <= col_d;
    end
  end

endmodule

[src/bracket_balance_checker_core.sv]
// top level: bracket balance checker with stack ram, position counters and verdict register
// the verdict is registered from the word marked end_of_text and is on the output in the cycle after that word is taken
// throughput: one word per cycle while no verdict waits on a stalled receiver; the top of stack
//   sits in a register and the ram is read ahead at the entry under it, with write forwarding
// reset: all control state clears at once; the stack ram needs no clearing pass
// after each verdict the state returns to its reset values for the next text
`timescale 1ns / 1ps
module bracket_balance_checker_core
  import bbc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  bbc_in_if.sink          in_i,
  bbc_out_if.source       out_o
);

  logic                      acc, live, last;
  logic [7:0]                c;
  logic [1:0]                ok_k, ck_k;
  logic                      is_open, is_close, is_full, is_empty;
  stk_cmd_t                  cmd;
  stk_stat_t                 stat;
  logic [POSITION_WIDTH-1:0] line_cur, col_cur;
  logic [2:0]                err_q, err_d;
  logic [7:0]                byte_q, byte_d;
  logic [POSITION_WIDTH-1:0] outer_line_q, outer_line_d, outer_col_q, outer_col_d;
  logic [1:0]                tos_nx;
  logic                      open_left;

  logic        out_valid_q;
  logic [2:0]  verdict_q, verdict_d;
  logic [15:0] line_out_q, line_out_d, col_out_q, col_out_d;
  logic [7:0]  char_out_q, char_out_d;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;
  assign c          = in_i.char_code;
  assign last       = in_i.end_of_text;
  assign live       = acc && (err_q == VERDICT_OK);
  assign ok_k       = opener_kind(c);
  assign ck_k       = closer_kind(c);
  assign is_open    = ok_k != KIND_NONE;
  assign is_close   = ck_k != KIND_NONE;
  assign is_full    = stat.level == LVL_W'(STACK_DEPTH);
  assign is_empty   = stat.level == '0;

  assign cmd.push  = live && is_open && !is_full;
  assign cmd.pop   = live && is_close && !is_empty;
  assign cmd.clear = acc && last;
  assign cmd.kind  = ok_k;

  bbc_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  bbc_pos u_pos (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (live),
    .newline_i (c == CH_NEWLINE),
    .clear_i   (acc && last),
    .line_o    (line_cur),
    .column_o  (col_cur)
  );

  always_comb begin
    err_d        = err_q;
    byte_d       = byte_q;
    outer_line_d = outer_line_q;
    outer_col_d  = outer_col_q;
    if (live) begin
      if (is_open && is_full) begin
        err_d  = VERDICT_OVERFLOW;
        byte_d = c;
      end else if (is_close && is_empty) begin
        err_d  = VERDICT_NO_OPENER;
        byte_d = c;
      end else if (is_close && (stat.tos != ck_k)) begin
        err_d  = VERDICT_MISMATCH;
        byte_d = c;
      end
      if (cmd.push && is_empty) begin
        outer_line_d = line_cur;
        outer_col_d  = col_cur;
      end
    end

    tos_nx    = cmd.push ? ok_k : (cmd.pop ? stat.below : stat.tos);
    open_left = cmd.push || (cmd.pop ? (stat.level != LVL_W'(1)) : !is_empty);

    if (err_d != VERDICT_OK) begin
      verdict_d  = err_d;
      line_out_d = 16'(line_cur);
      col_out_d  = 16'(col_cur);
      char_out_d = byte_d;
    end else if (open_left) begin
      verdict_d  = VERDICT_NO_CLOSER;
      line_out_d = 16'(outer_line_d);
      col_out_d  = 16'(outer_col_d);
      char_out_d = kind_char(tos_nx);
    end else begin
      verdict_d  = VERDICT_OK;
      line_out_d = '0;
      col_out_d  = '0;
      char_out_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q        <= VERDICT_OK;
      byte_q       <= '0;
      outer_line_q <= '0;
      outer_col_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (acc && last) begin
        err_q        <= VERDICT_OK;
        byte_q       <= '0;
        outer_line_q <= '0;
        outer_col_q  <= '0;
        out_valid_q  <= 1'b1;
      end else begin
        err_q        <= err_d;
        byte_q       <= byte_d;
        outer_line_q <= outer_line_d;
        outer_col_q  <= outer_col_d;
        if (out_o.ready) begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && last) begin
      verdict_q  <= verdict_d;
      line_out_q <= line_out_d;
      col_out_q  <= col_out_d;
      char_out_q <= char_out_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.verdict      = verdict_q;
  assign out_o.error_line   = line_out_q;
  assign out_o.error_column = col_out_q;
  assign out_o.error_char   = char_out_q;

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.level <= LVL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_no_stack_after_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != VERDICT_OK) |-> !(cmd.push || cmd.pop))
    else $error("stack moved after a latched error");

  a_verdict_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && last) |=> (out_valid_q && (stat.level == '0) && (err_q == VERDICT_OK)))
    else $error("no verdict or state not cleared after last word");

  a_ok_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (verdict_q == VERDICT_OK)) |->
      ((line_out_q == '0) && (col_out_q == '0) && (char_out_q == '0)))
    else $error("ok verdict with nonzero position");

endmodule

[verif/bbc_scoreboard.sv]
// scoreboard for the bracket balance checker: predicts verdicts and compares them
`timescale 1ns / 1ps
module bbc_scoreboard
  import bbc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  bbc_in_if                in_mon,
  bbc_out_if               out_mon,
  output int               fail_cnt,
  output int               pending_cnt,
  output int               word_cnt,
  output logic [4:0][31:0] verdict_hits
);

  typedef struct packed {
    logic [2:0]  verdict;
    logic [15:0] line;
    logic [15:0] column;
    logic [7:0]  chr;
  } verdict_t;

  verdict_t verdicts_due[$];

  logic [7:0]                opens[STACK_DEPTH];
  int                        depth;
  logic [POSITION_WIDTH-1:0] cur_line;
  logic [POSITION_WIDTH-1:0] cur_col;
  logic [POSITION_WIDTH-1:0] outer_line;
  logic [POSITION_WIDTH-1:0] outer_col;
  logic [2:0]                err_code;
  logic [7:0]                err_byte;

  task automatic clear_text_state();
    depth      = 0;
    cur_line   = POSITION_WIDTH'(1);
    cur_col    = '0;
    outer_line = '0;
    outer_col  = '0;
    err_code   = VERDICT_OK;
    err_byte   = '0;
  endtask

  task automatic report(input string field, input logic [15:0] got, input logic [15:0] want);
    $display("%0t ns verdict %s: got %0h, want %0h", $time, field, got, want);
    fail_cnt++;
  endtask

  // one text byte through the bracket tracker, verdict queued on the last byte
  task automatic track_byte(input logic [7:0] c, input logic last);
    verdict_t   v;
    logic [7:0] want_open;
    if (err_code == VERDICT_OK) begin
      if (c == CH_NEWLINE) begin
        if (cur_line != POS_MAX) cur_line = cur_line + 1'b1;
        cur_col = '0;
      end else if (cur_col != POS_MAX) begin
        cur_col = cur_col + 1'b1;
      end
      case (c)
        CH_RPAREN: want_open = CH_LPAREN;
        CH_RBRACK: want_open = CH_LBRACK;
        CH_RBRACE: want_open = CH_LBRACE;
        default:   want_open = 8'h00;
      endcase
      if (c == CH_LPAREN || c == CH_LBRACK || c == CH_LBRACE) begin
        if (depth == STACK_DEPTH) begin
          err_code = VERDICT_OVERFLOW;
          err_byte = c;
        end else begin
          if (depth == 0) begin
            outer_line = cur_line;
            outer_col  = cur_col;
          end
          opens[depth] = c;
          depth++;
        end
      end else if (want_open != 8'h00) begin
        if (depth == 0) begin
          err_code = VERDICT_NO_OPENER;
          err_byte = c;
        end else begin
          depth--;
          if (opens[depth] != want_open) begin
            err_code = VERDICT_MISMATCH;
            err_byte = c;
          end
        end
      end
    end
    if (last) begin
      v = '0;
      if (err_code != VERDICT_OK) begin
        v.verdict = err_code;
        v.line    = cur_line[15:0];
        v.column  = cur_col[15:0];
        v.chr     = err_byte;
      end else if (depth != 0) begin
        v.verdict = VERDICT_NO_CLOSER;
        v.line    = outer_line[15:0];
        v.column  = outer_col[15:0];
        v.chr     = opens[depth-1];
      end
      verdicts_due.push_back(v);
      clear_text_state();
    end
  endtask

  task automatic check_verdict();
    verdict_t want;
    if (verdicts_due.size() == 0) begin
      report("with no text pending", 16'(out_mon.verdict), '0);
    end else begin
      want = verdicts_due.pop_front();
      verdict_hits[want.verdict] = verdict_hits[want.verdict] + 1;
      if (out_mon.verdict !== want.verdict)
        report("code", 16'(out_mon.verdict), 16'(want.verdict));
      if (out_mon.error_line !== want.line) report("line", out_mon.error_line, want.line);
      if (out_mon.error_column !== want.column)
        report("column", out_mon.error_column, want.column);
      if (out_mon.error_char !== want.chr)
        report("char", 16'(out_mon.error_char), 16'(want.chr));
    end
  endtask

  // verdict words leave before the word taken at the same edge can cause one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_text_state();
      verdicts_due.delete();
      fail_cnt     = 0;
      pending_cnt  = 0;
      word_cnt     = 0;
      verdict_hits = '0;
    end else begin
      if (out_mon.valid && out_mon.ready) check_verdict();
      if (in_mon.valid && in_mon.ready) begin
        track_byte(in_mon.char_code, in_mon.end_of_text);
        word_cnt++;
      end
      pending_cnt = verdicts_due.size();
    end
  end

endmodule

[verif/testbench.sv]
// testbench top for the bracket balance checker: clock, reset, text stimulus and verdict
`timescale 1ns / 1ps
module testbench;
  import bbc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 200;
  localparam int PHASE_WORDS    = 250;

  typedef enum int {
    SHAPE_CLEAN, SHAPE_UNCLOSED, SHAPE_CROSSED, SHAPE_STRAY, SHAPE_DEEP, SHAPE_NOISE
  } text_shape_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  bbc_in_if  in_ch();
  bbc_out_if out_ch();

  int               fail_cnt;
  int               pending_cnt;
  int               word_cnt;
  logic [4:0][31:0] verdict_hits;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int hold_served;
  int word_total;
  int text_total;
  int idle_cycles;

  logic [7:0] text_q[$];

  bracket_balance_checker_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  bbc_scoreboard chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_cnt     (fail_cnt),
    .pending_cnt  (pending_cnt),
    .word_cnt     (word_cnt),
    .verdict_hits (verdict_hits)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [7:0] opener_of(input int k);
    case (k)
      0:       return CH_LPAREN;
      1:       return CH_LBRACK;
      default: return CH_LBRACE;
    endcase
  endfunction

  function automatic logic [7:0] closer_of(input int k);
    case (k)
      0:       return CH_RPAREN;
      1:       return CH_RBRACK;
      default: return CH_RBRACE;
    endcase
  endfunction

  function automatic int kind_of(input logic [7:0] o);
    if (o == CH_LPAREN) return 0;
    if (o == CH_LBRACK) return 1;
    return 2;
  endfunction

  function automatic logic is_bracket(input logic [7:0] c);
    return c == CH_LPAREN || c == CH_LBRACK || c == CH_LBRACE ||
           c == CH_RPAREN || c == CH_RBRACK || c == CH_RBRACE;
  endfunction

  function automatic logic [7:0] filler_byte();
    logic [7:0] c;
    if ($urandom_range(99) < 12) return CH_NEWLINE;
    do c = 8'($urandom_range(255)); while (is_bracket(c));
    return c;
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_served  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served++;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", idle_cycles);
      $display("bracket_balance_checker_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.char_code   <= c;
    in_ch.end_of_text <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    word_total++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_word(text_q[i], i == text_q.size() - 1);
    text_total++;
  endtask

  task automatic send_str(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text();
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
  endtask

  task automatic build_text();
    logic [7:0]  open_q[$];
    text_shape_e shape;
    int          r;
    int          len;
    int          max_depth;
    int          k;
    text_q.delete();
    r = $urandom_range(99);
    if (r < 45)      shape = SHAPE_CLEAN;
    else if (r < 57) shape = SHAPE_UNCLOSED;
    else if (r < 69) shape = SHAPE_CROSSED;
    else if (r < 81) shape = SHAPE_STRAY;
    else if (r < 84) shape = SHAPE_DEEP;
    else             shape = SHAPE_NOISE;
    len       = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 16);
    max_depth = ($urandom_range(19) == 0) ? STACK_DEPTH : $urandom_range(1, 8);
    if (shape == SHAPE_NOISE) begin
      repeat ($urandom_range(1, 20)) text_q.push_back(8'($urandom_range(255)));
      return;
    end
    if (shape == SHAPE_DEEP) begin
      repeat ($urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 6))
        text_q.push_back(opener_of($urandom_range(2)));
      repeat ($urandom_range(5)) text_q.push_back(8'($urandom_range(255)));
      return;
    end
    repeat (len) begin
      r = $urandom_range(99);
      if (r < 25 && open_q.size() < max_depth) begin
        open_q.push_back(opener_of($urandom_range(2)));
        text_q.push_back(open_q[$]);
      end else if (r < 50 && open_q.size() > 0) begin
        text_q.push_back(closer_of(kind_of(open_q.pop_back())));
      end else begin
        text_q.push_back(filler_byte());
      end
    end
    case (shape)
      SHAPE_UNCLOSED: begin
        if (open_q.size() == 0) text_q.push_back(opener_of($urandom_range(2)));
        if ($urandom_range(1)) text_q.push_back(filler_byte());
      end
      SHAPE_CROSSED: begin
        k = $urandom_range(2);
        text_q.push_back(opener_of(k));
        text_q.push_back(closer_of((k + $urandom_range(1, 2)) % 3));
        repeat ($urandom_range(4)) text_q.push_back(8'($urandom_range(255)));
      end
      SHAPE_STRAY: begin
        while (open_q.size() > 0) text_q.push_back(closer_of(kind_of(open_q.pop_back())));
        text_q.push_back(closer_of($urandom_range(2)));
        repeat ($urandom_range(4)) text_q.push_back(8'($urandom_range(255)));
      end
      default: begin
        while (open_q.size() > 0) text_q.push_back(closer_of(kind_of(open_q.pop_back())));
      end
    endcase
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.char_code   = '0;
    in_ch.end_of_text = 1'b0;
    rst_ni            = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_requests     = 0;
    word_total        = 0;
    text_total        = 0;
    idle_cycles       = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // short texts: extreme bytes, every verdict but overflow, errors followed by ignored bytes
    text_q = '{8'h00};
    send_text();
    text_q = '{8'hFF};
    send_text();
    send_str("()");
    send_str("{\n}");
    send_str("{");
    send_str(")");
    send_str("(]");
    send_str("a\n[}");
    send_str("([{");
    send_str(")((");
    send_str("\n");
    send_str("[x]\n(");

    // full stack is fine, one more opener overflows
    text_q.delete();
    repeat (STACK_DEPTH) text_q.push_back(opener_of($urandom_range(2)));
    for (int i = STACK_DEPTH - 1; i >= 0; i--) text_q.push_back(closer_of(kind_of(text_q[i])));
    send_text();
    text_q.delete();
    repeat (STACK_DEPTH + 1) text_q.push_back(CH_LBRACK);
    text_q.push_back(CH_RBRACK);
    send_text();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      word_total = 0;
      while (word_total < PHASE_WORDS) begin
        build_text();
        send_text();
      end
      if (phase == 1) begin
        // receiver blocked while random texts keep coming
        hold_requests++;
        repeat (6) begin
          build_text();
          send_text();
        end
        wait_drained();
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    $display("checked %0d words in %0d texts; verdicts ok %0d, missing opener %0d,",
             word_cnt, text_total, verdict_hits[VERDICT_OK], verdict_hits[VERDICT_NO_OPENER]);
    $display("mismatch %0d, missing closer %0d, overflow %0d, under four stall mixes",
             verdict_hits[VERDICT_MISMATCH], verdict_hits[VERDICT_NO_CLOSER],
             verdict_hits[VERDICT_OVERFLOW]);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("bracket_balance_checker_core: match");
    end else begin
      $display("bracket_balance_checker_core: mismatch");
    end
    $finish;
  end

endmodule

[bracket_balance_checker_core.f]
src/bbc_pkg.sv
src/bbc_if.sv
src/bbc_stack.sv
src/bbc_pos.sv
src/bracket_balance_checker_core.sv
verif/bbc_scoreboard.sv
verif/testbench.sv
